FILE: src/gpc_pkg.sv
// Shared types, constants and helpers of the grid path counter.
package gpc_pkg;

  localparam int COUNT_BITS   = 32;
  localparam int MAX_COLS     = 64;
  localparam int MAX_ROWS     = 64;
  localparam int COL_BITS     = $clog2(MAX_COLS);
  localparam int ROW_BITS     = $clog2(MAX_ROWS);
  localparam int REG_BITS     = 7;
  localparam int CFG_IDX_BITS = 1;
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = $clog2(QDEPTH);

  localparam logic [REG_BITS-1:0] MAX_COLS_V = REG_BITS'(MAX_COLS);
  localparam logic [REG_BITS-1:0] MAX_ROWS_V = REG_BITS'(MAX_ROWS);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_COLS = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;

  // One classified cell, passed from the front to the back
  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic                blocked;
    logic                first_cell;
    logic                top_row;
    logic                left_col;
    logic                last_cell;
  } cell_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Last index in use for a dimension register: zero acts as one, large values clamp.
  function automatic logic [REG_BITS-1:0] last_index(input logic [REG_BITS-1:0] v,
                                                     input logic [REG_BITS-1:0] limit);
    logic [REG_BITS-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > limit) begin
      res = limit - REG_BITS'(1);
    end else begin
      res = v - REG_BITS'(1);
    end
    return res;
  endfunction

endpackage

FILE: src/grid_path_counter_obstacles_unit.sv
// Top level of the grid path counter with obstacle cells.
//
//  channel   direction  handshake            payload
//  in_       request in push / full          in_blocked
//  out_      request out empty / pop         out_path_total, out_overflowed
//  cfg_      write in   cfg_we               cfg_index, cfg_wdata
//
// One cell request is taken every cycle while the cell queue is not full;
// the back end does one add and one row-buffer read-and-write per cell, so
// that stage sets the rate. The last cell's count is registered as the result.
// Reset is synchronous; no clearing pass, the row buffer is written before read.
// A result held on the output stalls the back end only at the next grid's last
// cell; the four-entry cell queue then fills and full rises.
module grid_path_counter_obstacles_unit import gpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]     cfg_wdata,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic                    in_blocked,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [COUNT_BITS-1:0]   out_path_total,
  output logic                    out_overflowed
);

  logic    q_push, q_pop;
  cell_t   q_wr_cell, q_rd_cell;
  q_stat_t q_stat;

  // Front: track row and column, classify each cell
  gpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (in_push),
    .blocked   (in_blocked),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_cell    (q_wr_cell)
  );

  // Hold classified cells until the back end is free
  gpc_cellq u_cellq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_cell (q_wr_cell),
    .pop     (q_pop),
    .rd_cell (q_rd_cell),
    .stat    (q_stat)
  );

  // Back: advance the row of counts and produce the total
  gpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .q_empty    (q_stat.empty),
    .q_cell     (q_rd_cell),
    .q_pop      (q_pop),
    .pop        (out_pop),
    .out_empty  (out_empty),
    .path_total (out_path_total),
    .overflowed (out_overflowed)
  );

  assign in_full = q_stat.full;

  // The cell queue never reports full and empty at once
  a_q_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("cell queue both full and empty");

  // A request taken into an empty queue is visible to the back end next cycle
  a_q_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_stat.empty) |=> !q_stat.empty)
    else $error("cell queue lost a request");

  // Reset drops any waiting result
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

endmodule

FILE: src/gpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/gpc_front.sv
// Front end: configuration registers, cell position tracking and classification.
module gpc_front import gpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]     cfg_wdata,
  input  logic                    push,
  input  logic                    blocked,
  input  logic                    q_full,
  output logic                    q_push,
  output cell_t                   q_cell
);

  logic [REG_BITS-1:0] rows_r, rows_nxt;
  logic [REG_BITS-1:0] cols_r, cols_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic [COL_BITS-1:0] col_r, col_nxt;
  logic [REG_BITS-1:0] last_row_w, last_col_w;
  logic                col_end, row_end, accept, restart;

  assign last_row_w = last_index(rows_r, MAX_ROWS_V);
  assign last_col_w = last_index(cols_r, MAX_COLS_V);
  assign col_end    = col_r >= last_col_w[COL_BITS-1:0];
  assign row_end    = row_r >= last_row_w[ROW_BITS-1:0];
  assign accept     = push & ~q_full;

  assign q_push            = accept;
  assign q_cell.col        = col_r;
  assign q_cell.blocked    = blocked;
  assign q_cell.first_cell = (row_r == '0) && (col_r == '0);
  assign q_cell.top_row    = (row_r == '0);
  assign q_cell.left_col   = (col_r == '0);
  assign q_cell.last_cell  = col_end && row_end;

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    restart  = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: begin
          rows_nxt = cfg_wdata;
          restart  = 1'b1;
        end
        REG_GRID_COLS: begin
          cols_nxt = cfg_wdata;
          restart  = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + ROW_BITS'(1);
      end else begin
        col_nxt = col_r + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= REG_BITS'(1);
      cols_r <= REG_BITS'(1);
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

FILE: src/gpc_cellq.sv
// Short queue of classified cells between the front and the back.
module gpc_cellq import gpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cell_t   wr_cell,
  input  logic    pop,
  output cell_t   rd_cell,
  output q_stat_t stat
);

  cell_t                ent_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   count_r, count_nxt;

  assign stat.full  = (count_r == (QPTR_BITS+1)'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_cell    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_BITS'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_BITS+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wr_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/gpc_back.sv
// Back end: row buffer, saturating cell sum and result register.
module gpc_back import gpc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   restart,
  input  logic   q_empty,
  input  cell_t  q_cell,
  output logic   q_pop,
  input  logic   pop,
  output logic   out_empty,
  output count_t path_total,
  output logic   overflowed
);

  logic          s2_valid_r, s2_valid_nxt;
  cell_t         s2_cell_r;
  count_t        left_r, left_nxt;
  logic          sat_r, sat_nxt;
  logic          byp_r, byp_nxt;
  count_t        byp_data_r;
  logic          out_valid_r, out_valid_nxt;
  count_t        out_total_r;
  logic          out_ovf_r;
  count_t        ram_rdata, up, left, cell_cnt;
  logic [COUNT_BITS:0] sum;
  logic          sat_hit, s2_done, emit;

  gpc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_COLS)
  ) u_row_ram (
    .clk   (clk),
    .we    (s2_done),
    .waddr (s2_cell_r.col),
    .wdata (cell_cnt),
    .re    (q_pop),
    .raddr (q_cell.col),
    .rdata (ram_rdata)
  );

  always_comb begin
    up   = s2_cell_r.top_row  ? '0 : (byp_r ? byp_data_r : ram_rdata);
    left = s2_cell_r.left_col ? '0 : left_r;
    sum  = {1'b0, up} + {1'b0, left};
    sat_hit = 1'b0;
    if (s2_cell_r.blocked) begin
      cell_cnt = '0;
    end else if (s2_cell_r.first_cell) begin
      cell_cnt = COUNT_BITS'(1);
    end else if (sum[COUNT_BITS]) begin
      cell_cnt = '1;
      sat_hit  = 1'b1;
    end else begin
      cell_cnt = sum[COUNT_BITS-1:0];
    end
  end

  assign s2_done = s2_valid_r && (!s2_cell_r.last_cell || !out_valid_r || pop);
  assign q_pop   = !q_empty && (!s2_valid_r || s2_done);
  assign emit    = s2_done && s2_cell_r.last_cell;

  always_comb begin
    s2_valid_nxt = q_pop ? 1'b1 : (s2_done ? 1'b0 : s2_valid_r);
    // Forward a write that lands on the address being read in the same cycle
    byp_nxt      = q_pop ? (s2_done && (s2_cell_r.col == q_cell.col)) : byp_r;
    left_nxt     = left_r;
    sat_nxt      = sat_r;
    if (restart) begin
      left_nxt = '0;
      sat_nxt  = 1'b0;
    end else if (s2_done) begin
      left_nxt = cell_cnt;
      sat_nxt  = s2_cell_r.last_cell ? 1'b0 : (sat_r | sat_hit);
    end
    out_valid_nxt = emit ? 1'b1 : ((pop && out_valid_r) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_cell_r  <= q_cell;
      byp_data_r <= cell_cnt;
    end
    if (emit) begin
      out_total_r <= cell_cnt;
      out_ovf_r   <= sat_r | sat_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      byp_r       <= 1'b0;
      left_r      <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      byp_r       <= byp_nxt;
      left_r      <= left_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty  = !out_valid_r;
  assign path_total = out_total_r;
  assign overflowed = out_ovf_r;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the grid path counter with obstacle cells.
module tb_top import gpc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // One path-count result as it leaves the block
  typedef struct {
    count_t total;
    logic   ovf;
  } path_result_t;

  // Scoreboard: carries its own copy of the row buffer and grid position,
  // turns every accepted cell request into the path total it leads to and
  // keeps the totals still owed by the block.
  class path_count_board;
    logic [REG_BITS-1:0] rows_reg;
    logic [REG_BITS-1:0] cols_reg;
    count_t              row_cnt[MAX_COLS];
    count_t              left_cnt;
    int                  col_idx;
    int                  row_idx;
    logic                sat;
    path_result_t        totals_due[$];
    int                  errors;
    int                  cells;
    int                  grids;
    int                  sat_grids;
    int                  writes;

    function new();
      rows_reg = REG_BITS'(1);
      cols_reg = REG_BITS'(1);
      foreach (row_cnt[i]) row_cnt[i] = '0;
      errors    = 0;
      cells     = 0;
      grids     = 0;
      sat_grids = 0;
      writes    = 0;
      restart();
    endfunction

    function void restart();
      left_cnt = '0;
      col_idx  = 0;
      row_idx  = 0;
      sat      = 1'b0;
    endfunction

    // Zero acts as one, anything past the buffer clamps to it
    function int dim_in_use(input logic [REG_BITS-1:0] v, input int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
    endfunction

    function int cells_per_grid();
      return dim_in_use(rows_reg, MAX_ROWS) * dim_in_use(cols_reg, MAX_COLS);
    endfunction

    function void set_dim(input logic [CFG_IDX_BITS-1:0] idx,
                          input logic [REG_BITS-1:0] val);
      if (idx == REG_GRID_ROWS) rows_reg = val;
      else cols_reg = val;
      writes++;
      restart();
    endfunction

    function void take_cell(input logic blocked);
      int                  nrows;
      int                  ncols;
      count_t              cell_cnt;
      count_t              up;
      count_t              lf;
      logic [COUNT_BITS:0] sum;
      path_result_t        res;
      nrows = dim_in_use(rows_reg, MAX_ROWS);
      ncols = dim_in_use(cols_reg, MAX_COLS);
      cells++;
      if (blocked) begin
        cell_cnt = '0;
      end else if (row_idx == 0 && col_idx == 0) begin
        cell_cnt = count_t'(1);
      end else begin
        up  = (row_idx > 0) ? row_cnt[col_idx] : '0;
        lf  = (col_idx > 0) ? left_cnt : '0;
        sum = {1'b0, up} + {1'b0, lf};
        if (sum[COUNT_BITS]) begin
          cell_cnt = '1;
          sat      = 1'b1;
        end else begin
          cell_cnt = sum[COUNT_BITS-1:0];
        end
      end
      row_cnt[col_idx] = cell_cnt;
      left_cnt         = cell_cnt;
      if (col_idx + 1 >= ncols) begin
        col_idx  = 0;
        left_cnt = '0;
        if (row_idx + 1 >= nrows) begin
          res.total = cell_cnt;
          res.ovf   = sat;
          totals_due.insert(totals_due.size(), res);
          grids++;
          if (sat) sat_grids++;
          restart();
        end else begin
          row_idx++;
        end
      end else begin
        col_idx++;
      end
    endfunction

    function void check_total(input count_t got_total, input logic got_ovf);
      path_result_t due;
      if (totals_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: unrequested result total=%0d ovf=%0b", got_total, got_ovf);
        return;
      end
      due = totals_due.pop_front();
      if (got_total !== due.total || got_ovf !== due.ovf) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: total exp=%0d got=%0d, ovf exp=%0b got=%0b",
                   due.total, got_total, due.ovf, got_ovf);
      end
    endfunction

    function int pending();
      return totals_due.size();
    endfunction

    // Anything still owed at the end is a failure
    function void close_out();
      if (totals_due.size() != 0) begin
        errors += totals_due.size();
        $display("mismatch: %0d results never arrived", totals_due.size());
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_GRID_ROWS;
  logic [REG_BITS-1:0]     cfg_wdata = '0;
  logic                    in_push = 1'b0;
  logic                    in_full;
  logic                    in_blocked = 1'b0;
  logic                    out_empty;
  logic                    out_pop = 1'b0;
  logic [COUNT_BITS-1:0]   out_path_total;
  logic                    out_overflowed;

  path_count_board board = new();

  int send_idle_pct = 0;
  int pop_idle_pct  = 0;
  int pop_hold      = 0;   // cycles the result side still holds off
  int broken_grids  = 0;

  grid_path_counter_obstacles_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_blocked     (in_blocked),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_path_total (out_path_total),
    .out_overflowed (out_overflowed)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run here
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: check what was taken at this edge, then pick the next pop.
  // A pending hold-off keeps pop low and counts itself down here.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) board.check_total(out_path_total, out_overflowed);
    if (pop_hold > 0) begin
      pop_hold--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99, 0) >= pop_idle_pct);
    end
  end

  // Offer one cell request, with a random gap in front of it. Push stays high
  // after acceptance so back-to-back requests never drop it for a step.
  task automatic send_cell(input logic blocked);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_blocked <= blocked;
    do @(posedge clk); while (in_full);
    board.take_cell(blocked);
  endtask

  // Drop push, wait until every owed total has been taken, then let the
  // pipeline drain any partial-grid cells before touching the registers.
  task automatic settle();
    in_push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Write both dimension registers on consecutive edges; each write restarts
  // the grid in progress.
  task automatic write_dims(input logic [REG_BITS-1:0] r, input logic [REG_BITS-1:0] c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_ROWS;
    cfg_wdata <= r;
    @(posedge clk);
    board.set_dim(REG_GRID_ROWS, r);
    cfg_index <= REG_GRID_COLS;
    cfg_wdata <= c;
    @(posedge clk);
    board.set_dim(REG_GRID_COLS, c);
    cfg_we <= 1'b0;
  endtask

  // Obstacle bits, first cell in bit 0
  task automatic send_pattern(input logic [63:0] pat, input int n);
    for (int i = 0; i < n; i++) send_cell(pat[i]);
  endtask

  task automatic send_grid(input int n, input int density, input logic end_blocked);
    for (int i = 0; i < n; i++)
      send_cell((end_blocked && i == n - 1) ? 1'b1 : ($urandom_range(99, 0) < density));
  endtask

  // Obstacle density per grid: many clean grids, mostly sparse, a few dense
  function automatic int pick_density();
    int p;
    p = $urandom_range(99, 0);
    if (p < 30) return 0;
    if (p < 80) return $urandom_range(20, 1);
    return $urandom_range(100, 21);
  endfunction

  // One setting of the dimensions followed by a run of whole grids with
  // random obstacles, now and then cut short by the next register write.
  task automatic random_phase();
    int                  pick;
    int                  r;
    int                  c;
    int                  lim;
    int                  ngrids;
    logic [REG_BITS-1:0] r_raw;
    logic [REG_BITS-1:0] c_raw;
    pick = $urandom_range(99, 0);
    if (pick < 70) begin
      r = $urandom_range(6, 1);
      c = $urandom_range(6, 1);
    end else if (pick < 88) begin
      r = $urandom_range(12, 1);
      c = $urandom_range(12, 1);
    end else if (pick < 95) begin
      if ($urandom_range(1, 0)) begin
        r = 1;
        c = $urandom_range(64, 1);
      end else begin
        r = $urandom_range(64, 1);
        c = 1;
      end
    end else begin
      // big enough to saturate a 32-bit count when mostly free
      r = $urandom_range(22, 19);
      c = $urandom_range(22, 19);
    end
    r_raw = REG_BITS'(r);
    c_raw = REG_BITS'(c);
    if (r == 1 && $urandom_range(1, 0)) r_raw = '0;
    if (c == 1 && $urandom_range(1, 0)) c_raw = '0;
    if (r == 64 && $urandom_range(1, 0)) r_raw = REG_BITS'($urandom_range(127, 65));
    if (c == 64 && $urandom_range(1, 0)) c_raw = REG_BITS'($urandom_range(127, 65));
    settle();
    write_dims(r_raw, c_raw);
    lim = 120 / (r * c);
    if (lim > 9) lim = 9;
    ngrids = 1 + $urandom_range(lim, 0);
    for (int g = 0; g < ngrids; g++)
      send_grid(r * c, (r * c > 300) ? $urandom_range(3, 0) : pick_density(), 1'b0);
    if (r * c > 1 && $urandom_range(99, 0) < 12) begin
      send_grid($urandom_range(r * c - 1, 1), pick_density(), 1'b0);
      broken_grids++;
    end
  endtask

  initial begin
    int base;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Era one: sender rarely idles, result side idles often
    send_idle_pct = 10;
    pop_idle_pct  = 57;

    // Reset dimensions are one by one: free, then blocked single cell
    send_cell(1'b0);
    send_cell(1'b1);
    // Zero registers act as one
    settle();
    write_dims('0, '0);
    send_cell(1'b0);
    send_cell(1'b1);
    // Two by three: blocked start, blocked end, obstacle in the middle
    settle();
    write_dims(REG_BITS'(2), REG_BITS'(3));
    send_pattern(64'b000001, 6);
    send_pattern(64'b100000, 6);
    send_pattern(64'b000010, 6);
    // Break off a grid; the register write must restart it
    send_pattern(64'b0000, 4);
    broken_grids++;
    settle();
    write_dims(REG_BITS'(2), REG_BITS'(3));
    send_pattern(64'b000000, 6);

    base = board.cells;
    while (board.cells < base + 280) random_phase();

    // Era two: roles swapped
    send_idle_pct = 57;
    pop_idle_pct  = 10;
    while (board.cells < base + 560) random_phase();

    // Era three: no idling. Hold off the result side while single-cell grids
    // keep coming so the cell queue fills and full rises, then drain.
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    settle();
    write_dims(REG_BITS'(1), REG_BITS'(1));
    pop_hold = 200;
    for (int i = 0; i < 40; i++) send_cell(1'($urandom_range(1, 0)));
    settle();
    while (board.cells < base + 780) random_phase();

    // Largest settings: one column, one row, and a saturating grid whose
    // end is blocked
    settle();
    write_dims(REG_BITS'(65), REG_BITS'(1));
    send_grid(64, 5, 1'b0);
    send_grid(64, 0, 1'b0);
    settle();
    write_dims('0, REG_BITS'(64));
    send_grid(64, 0, 1'b0);
    send_grid(64, 2, 1'b0);
    settle();
    write_dims(REG_BITS'(20), REG_BITS'(20));
    send_grid(400, 0, 1'b1);
    send_grid(400, 1, 1'b0);

    // Wait out every owed total, then the block's latency
    in_push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    board.close_out();

    $display("covered %0d grids over %0d cell requests, %0d of them saturating,",
             board.grids, board.cells, board.sat_grids);
    $display("%0d register writes and %0d grids cut short by a restart",
             board.writes, broken_grids);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
